// ===== src/salct_pkg.sv =====
// Shared constants, types and helper functions for the set-associative LRU tracker.
`timescale 1ns / 1ps

package salct_pkg;

    // Cache geometry
    localparam int WAYS      = 4;
    localparam int SETS      = 128;
    localparam int ADDR_BITS = 32;

    // Configuration limits and reset values
    localparam int OFFSET_MIN   = 2;
    localparam int OFFSET_MAX   = 12;
    localparam int OFF_W        = 4;
    localparam int SB_W         = 3;
    localparam int OFFSET_RST   = 6;
    localparam int SET_BITS_RST = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = CFG_IDX_W'(1);

    function automatic int floor_log2(input int n);
        int r;
        r = 0;
        for (int i = 0; i < 31; i++) begin
            if ((64'd1 << (i + 1)) <= 64'(n)) begin
                r = i + 1;
            end
        end
        return r;
    endfunction

    localparam int SET_LOG2 = floor_log2(SETS);
    localparam int ROWS     = 1 << SET_LOG2;
    localparam int ROW_AW   = (SET_LOG2 > 0) ? SET_LOG2 : 1;
    localparam int SB_MAX   = (SET_LOG2 < ((1 << SB_W) - 1)) ? SET_LOG2 : ((1 << SB_W) - 1);

    localparam int TAG_W   = ADDR_BITS - OFFSET_MIN;
    localparam int SHIFT_W = $clog2(OFFSET_MAX + SB_MAX + 1);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LRU_W   = WAYS * WAY_W;
    localparam int OUT_WAY_W = 2;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One RAM row holds a whole set
    typedef struct packed {
        logic [LRU_W-1:0]               lru;    // position 0 = least recent
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0][TAG_W-1:0]     tag;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch item, split address
        logic rd;       // read set row
        logic commit;   // compare, write back, publish result
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_stall;    // output register full and not being taken
    } t_stat;

    function automatic logic [LRU_W-1:0] lru_reset();
        logic [LRU_W-1:0] r;
        r = '0;
        for (int i = 0; i < WAYS; i++) begin
            r[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return r;
    endfunction

    localparam logic [LRU_W-1:0] LRU_RST = lru_reset();

endpackage

// ===== src/salct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/salct_ctrl.sv =====
// Sequencer for the tracker: accept, row read, compare and write back.
`timescale 1ns / 1ps

module salct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  salct_pkg::t_stat   i_stat,
    output salct_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                // hold here while the previous result is still unread
                if (!i_stat.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("accepted item did not start a row read");

    a_read_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_CMP))
        else $error("row read not followed by compare");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_stat.out_stall)
        else $error("commit while output register blocked");
`endif

endmodule

// ===== src/salct_dp.sv =====
// Datapath: config registers, address split, set RAM, LRU update, counters, result.
`timescale 1ns / 1ps

module salct_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  salct_pkg::t_cmd                        i_cmd,
    output salct_pkg::t_stat                       o_stat,
    input  logic                                   i_mode,
    input  logic [salct_pkg::ADDR_BITS-1:0]        i_address,
    input  logic                                   i_cfg_we,
    input  logic [salct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [salct_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_hit,
    output logic [salct_pkg::OUT_WAY_W-1:0]        o_way_used,
    output logic [salct_pkg::CNT_W-1:0]            o_read_requests,
    output logic [salct_pkg::CNT_W-1:0]            o_read_hits,
    output logic [salct_pkg::CNT_W-1:0]            o_write_requests,
    output logic [salct_pkg::CNT_W-1:0]            o_write_hits
);

    // config
    logic [salct_pkg::OFF_W-1:0]   r_offset_bits;
    logic [salct_pkg::SB_W-1:0]    r_set_bits;

    // latched item
    logic                          r_mode;
    logic [salct_pkg::ROW_AW-1:0]  r_set;
    logic [salct_pkg::TAG_W-1:0]   r_tag;

    // per-set written flags
    logic [salct_pkg::ROWS-1:0]    r_row_init;

    // counters and result
    logic [salct_pkg::CNT_W-1:0]   r_rd_cnt, r_rd_hit, r_wr_cnt, r_wr_hit;
    logic [salct_pkg::CNT_W-1:0]   n_rd_cnt, n_rd_hit, n_wr_cnt, n_wr_hit;
    logic                          r_out_valid;
    logic                          r_hit;
    logic [salct_pkg::WAY_W-1:0]   r_way;

    // address split
    logic [salct_pkg::OFF_W-1:0]   off_c;
    logic [salct_pkg::SB_W-1:0]    sb_c;
    logic [salct_pkg::SHIFT_W-1:0] tag_shift;
    logic [salct_pkg::ADDR_BITS-1:0] set_full, tag_full;
    logic [salct_pkg::ROW_AW-1:0]  set_mask;

    // compare step
    salct_pkg::t_row               rdata, cur, nrow;
    logic                          hit;
    logic [salct_pkg::WAY_W-1:0]   way;
    logic [salct_pkg::WAYS-1:0]    pos_match;
    logic [salct_pkg::WAYS-1:0]    shl;
    logic                          seen;
    logic [salct_pkg::LRU_W-1:0]   lru_shifted;
    logic [salct_pkg::LRU_W-1:0]   lru_new;
    logic [salct_pkg::ROW_W-1:0]   ram_rdata;

    // ---- config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= salct_pkg::OFF_W'(salct_pkg::OFFSET_RST);
            r_set_bits    <= salct_pkg::SB_W'(salct_pkg::SET_BITS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                salct_pkg::REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[salct_pkg::OFF_W-1:0];
                salct_pkg::REG_SET_BITS:    r_set_bits    <= i_cfg_data[salct_pkg::SB_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- address split with clamped field sizes
    always_comb begin
        off_c = r_offset_bits;
        if (r_offset_bits < salct_pkg::OFF_W'(salct_pkg::OFFSET_MIN)) begin
            off_c = salct_pkg::OFF_W'(salct_pkg::OFFSET_MIN);
        end
        if (r_offset_bits > salct_pkg::OFF_W'(salct_pkg::OFFSET_MAX)) begin
            off_c = salct_pkg::OFF_W'(salct_pkg::OFFSET_MAX);
        end
        sb_c = r_set_bits;
        if (r_set_bits > salct_pkg::SB_W'(salct_pkg::SB_MAX)) begin
            sb_c = salct_pkg::SB_W'(salct_pkg::SB_MAX);
        end
        tag_shift = salct_pkg::SHIFT_W'(off_c) + salct_pkg::SHIFT_W'(sb_c);
        set_full  = i_address >> off_c;
        tag_full  = i_address >> tag_shift;
        for (int b = 0; b < salct_pkg::ROW_AW; b++) begin
            set_mask[b] = (b < int'(sb_c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_set  <= set_full[salct_pkg::ROW_AW-1:0] & set_mask;
            r_tag  <= tag_full[salct_pkg::TAG_W-1:0];
        end
    end

    // ---- set RAM: one row per set
    salct_ram #(
        .WIDTH (salct_pkg::ROW_W),
        .DEPTH (salct_pkg::ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_set),
        .i_wdata (nrow),
        .i_re    (i_cmd.rd),
        .i_raddr (r_set),
        .o_rdata (ram_rdata)
    );

    assign rdata = ram_rdata;

    // ---- tag compare and LRU update
    always_comb begin
        cur = rdata;
        if (!r_row_init[r_set]) begin
            cur.valid = '0;
            cur.lru   = salct_pkg::LRU_RST;
        end

        // lowest matching valid way wins
        hit = 1'b0;
        way = cur.lru[salct_pkg::WAY_W-1:0];
        for (int w = salct_pkg::WAYS - 1; w >= 0; w--) begin
            if (cur.valid[w] && (cur.tag[w] == r_tag)) begin
                hit = 1'b1;
                way = salct_pkg::WAY_W'(w);
            end
        end

        // move the used way to the most-recent end
        seen = 1'b0;
        for (int j = 0; j < salct_pkg::WAYS; j++) begin
            pos_match[j] = (cur.lru[j*salct_pkg::WAY_W +: salct_pkg::WAY_W] == way);
            seen         = seen | pos_match[j];
            shl[j]       = seen;
        end
        lru_shifted = (cur.lru >> salct_pkg::WAY_W)
                    | (salct_pkg::LRU_W'(way) << (salct_pkg::LRU_W - salct_pkg::WAY_W));
        for (int j = 0; j < salct_pkg::WAYS; j++) begin
            lru_new[j*salct_pkg::WAY_W +: salct_pkg::WAY_W] = shl[j]
                ? lru_shifted[j*salct_pkg::WAY_W +: salct_pkg::WAY_W]
                : cur.lru[j*salct_pkg::WAY_W +: salct_pkg::WAY_W];
        end

        nrow     = cur;
        nrow.lru = lru_new;
        if (!hit) begin
            nrow.tag[way]   = r_tag;
            nrow.valid[way] = 1'b1;
        end
    end

    // ---- saturating counters
    always_comb begin
        n_rd_cnt = r_rd_cnt;
        n_rd_hit = r_rd_hit;
        n_wr_cnt = r_wr_cnt;
        n_wr_hit = r_wr_hit;
        if (r_mode) begin
            if (r_wr_cnt != salct_pkg::CNT_MAX) n_wr_cnt = r_wr_cnt + 1'b1;
            if (hit && (r_wr_hit != salct_pkg::CNT_MAX)) n_wr_hit = r_wr_hit + 1'b1;
        end else begin
            if (r_rd_cnt != salct_pkg::CNT_MAX) n_rd_cnt = r_rd_cnt + 1'b1;
            if (hit && (r_rd_hit != salct_pkg::CNT_MAX)) n_rd_hit = r_rd_hit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init  <= '0;
            r_rd_cnt    <= '0;
            r_rd_hit    <= '0;
            r_wr_cnt    <= '0;
            r_wr_hit    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_row_init[r_set] <= 1'b1;
                r_rd_cnt          <= n_rd_cnt;
                r_rd_hit          <= n_rd_hit;
                r_wr_cnt          <= n_wr_cnt;
                r_wr_hit          <= n_wr_hit;
                r_out_valid       <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= hit;
            r_way <= way;
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_way_used       = salct_pkg::OUT_WAY_W'(r_way);
    // counters only move on commit, so they are the result fields directly
    assign o_read_requests  = r_rd_cnt;
    assign o_read_hits      = r_rd_hit;
    assign o_write_requests = r_wr_cnt;
    assign o_write_hits     = r_wr_hit;

`ifndef SYNTHESIS
    a_rd_hits_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_hit <= r_rd_cnt)
        else $error("read hits exceed read requests");

    a_wr_hits_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_hit <= r_wr_cnt)
        else $error("write hits exceed write requests");

    a_rd_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_mode && (r_rd_cnt != salct_pkg::CNT_MAX))
        |=> (r_rd_cnt == salct_pkg::CNT_W'($past(r_rd_cnt) + 1'b1)))
        else $error("read request count did not advance");
`endif

endmodule

// ===== src/set_assoc_lru_cache_tracker_top.sv =====
// Top level of the set-associative LRU cache tag tracker.
`timescale 1ns / 1ps

// Tag-only tracker for a 4-way, 128-set cache with true LRU replacement.
// Each input item (mode, address) is split into block offset, set index and
// tag using the offset_bits and set_bits registers (offset clamped to 2..12,
// set bits clamped to 7). A hit is a valid way of the set with an equal tag;
// the lowest such way wins. On a miss the set's least-recent way takes the
// tag. Either way the used way becomes most recent. Every item gives one
// result: hit, way_used and the four saturating 32-bit request/hit counters
// after this access.
// Steps: an item is latched and its address split, then the set's row is
// read from the tag/LRU RAM (registered read), then it is compared, the row
// written back and the result loaded. A new item is taken the cycle after the
// previous one is written back, so items do not overlap. A result that sits
// unread in the output register holds the next item in its compare step.
// Reset: per-set "row written" flags clear at once, so there is no clearing
// pass; a set never written reads as all ways invalid, LRU order 0,1,2,3.
// Configuration: index 0 = offset_bits, index 1 = set_bits, other indexes
// are ignored. Write only while the block is idle; the port is always ready.
module set_assoc_lru_cache_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // access items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [salct_pkg::ADDR_BITS-1:0]     i_address,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [salct_pkg::OUT_WAY_W-1:0]     o_way_used,
    output logic [salct_pkg::CNT_W-1:0]         o_read_requests,
    output logic [salct_pkg::CNT_W-1:0]         o_read_hits,
    output logic [salct_pkg::CNT_W-1:0]         o_write_requests,
    output logic [salct_pkg::CNT_W-1:0]         o_write_hits,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [salct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [salct_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    salct_pkg::t_cmd  cmd;
    salct_pkg::t_stat stat;

    // register writes need no back-pressure
    assign o_cfg_ready = 1'b1;

    // sequencer
    salct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // lookup, replacement, counters and result register
    salct_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_address        (i_address),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_way_used       (o_way_used),
        .o_read_requests  (o_read_requests),
        .o_read_hits      (o_read_hits),
        .o_write_requests (o_write_requests),
        .o_write_hits     (o_write_hits)
    );

endmodule
